// ===== sv/ima_enc_pkg.sv =====
// ima_enc_pkg: types, constants and tables of the ima adpcm encoder
// no dependencies; imported by the interfaces and all modules
`timescale 1ns / 1ps

package ima_enc_pkg;

	// channel count and field widths
	localparam int CHANNELS = 2;
	localparam int CHAN_W   = 1;
	localparam int SAMPLE_W = 16;
	localparam int IDX_W    = 7;
	localparam int STEP_W   = 15;
	localparam int NIB_W    = 4;
	localparam int BYTE_W   = 8;

	localparam logic [IDX_W-1:0] STEP_MAX_INDEX = 7'd88;
	localparam logic signed [SAMPLE_W+1:0] PRED_MAX = 18'sd32767;
	localparam logic signed [SAMPLE_W+1:0] PRED_MIN = -18'sd32767;

	typedef logic [CHAN_W-1:0]          chan_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [IDX_W-1:0]           idx_t;
	typedef logic [STEP_W-1:0]          step_t;
	typedef logic [NIB_W-1:0]           nibble_t;
	typedef logic [BYTE_W-1:0]          byte_t;

	// predictor state of one channel, as seen by the coder
	typedef struct packed {
		sample_t pred;
		idx_t    idx;
	} chan_state_t;

	// coder result: code nibble and next predictor state
	typedef struct packed {
		nibble_t code;
		sample_t pred;
		idx_t    idx;
	} quant_res_t;

	// quantizer step sizes, 89 entries
	localparam step_t STEP_TABLE [89] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
		15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
		15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
		15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
		15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
		15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749,
		15'd3024,
		15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894,
		15'd6484,
		15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
		15'd13899,
		15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385, 15'd24623,
		15'd27086, 15'd29794,
		15'd32767
	};

	// step index adjustment by magnitude bits
	localparam logic signed [4:0] INDEX_ADJUST [8] = '{
		-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
	};

endpackage

// ===== sv/ima_enc_in_if.sv =====
// ima_enc_in_if: sample channel of the encoder (valid, ready, payload)
// depends on ima_enc_pkg
`timescale 1ns / 1ps

interface ima_enc_in_if
	import ima_enc_pkg::*;
();
	logic    valid;
	logic    ready;
	chan_t   chan;
	sample_t sample;
	logic    block_start;

	modport source (output valid, output chan, output sample, output block_start,
		input ready);
	modport sink (input valid, input chan, input sample, input block_start,
		output ready);
endinterface

// ===== sv/ima_enc_out_if.sv =====
// ima_enc_out_if: code byte channel of the encoder (valid, ready, payload)
// depends on ima_enc_pkg
`timescale 1ns / 1ps

interface ima_enc_out_if
	import ima_enc_pkg::*;
();
	logic  valid;
	logic  ready;
	chan_t out_chan;
	byte_t code_byte;

	modport source (output valid, output out_chan, output code_byte, input ready);
	modport sink (input valid, input out_chan, input code_byte, output ready);
endinterface

// ===== sv/ima_enc_quant.sv =====
// ima_enc_quant: combinational adpcm coder for one sample
// codes the sample against the predictor and step, rebuilds the predictor
// depends on ima_enc_pkg
`timescale 1ns / 1ps

module ima_enc_quant
	import ima_enc_pkg::*;
(
	input  sample_t     smp,
	input  chan_state_t st,
	output quant_res_t  res
);

	idx_t                   idx_lim;
	step_t                  step;
	logic signed [SAMPLE_W:0] diff;
	logic [SAMPLE_W:0]      mag0, mag1, mag2;
	logic                   neg, b2, b1, b0;
	logic [SAMPLE_W:0]      recon;
	logic signed [SAMPLE_W+1:0] pred_ext, pred_sum;
	logic signed [IDX_W+1:0] idx_sum;

	// step lookup, index held within the table
	assign idx_lim = (st.idx > STEP_MAX_INDEX) ? STEP_MAX_INDEX : st.idx;
	assign step    = STEP_TABLE[idx_lim];

	// sign and three magnitude bits by successive compare and subtract
	always_comb begin
		diff = {smp[SAMPLE_W-1], smp} - {st.pred[SAMPLE_W-1], st.pred};
		neg  = diff[SAMPLE_W];
		mag0 = neg ? (SAMPLE_W+1)'(-diff) : (SAMPLE_W+1)'(diff);
		b2   = mag0 >= {2'b00, step};
		mag1 = b2 ? (mag0 - {2'b00, step}) : mag0;
		b1   = mag1 >= {3'b000, step[STEP_W-1:1]};
		mag2 = b1 ? (mag1 - {3'b000, step[STEP_W-1:1]}) : mag1;
		b0   = mag2 >= {4'b0000, step[STEP_W-1:2]};
	end

	// predictor rebuild and clamp
	always_comb begin
		recon = {5'b00000, step[STEP_W-1:3]};
		if (b2) recon = recon + {2'b00, step};
		if (b1) recon = recon + {3'b000, step[STEP_W-1:1]};
		if (b0) recon = recon + {4'b0000, step[STEP_W-1:2]};
		pred_ext = {{2{st.pred[SAMPLE_W-1]}}, st.pred};
		if (neg) pred_sum = pred_ext - $signed({1'b0, recon});
		else     pred_sum = pred_ext + $signed({1'b0, recon});
	end

	// step index update and clamp
	assign idx_sum = $signed({2'b00, idx_lim}) + {{4{INDEX_ADJUST[{b2, b1, b0}][4]}},
		INDEX_ADJUST[{b2, b1, b0}]};

	always_comb begin
		res.code = {neg, b2, b1, b0};
		priority if (pred_sum > PRED_MAX) res.pred = PRED_MAX[SAMPLE_W-1:0];
		else if (pred_sum < PRED_MIN)     res.pred = PRED_MIN[SAMPLE_W-1:0];
		else                              res.pred = pred_sum[SAMPLE_W-1:0];
		priority if (idx_sum < 0)                       res.idx = '0;
		else if (idx_sum > $signed({2'b00, STEP_MAX_INDEX})) res.idx = STEP_MAX_INDEX;
		else                                            res.idx = idx_sum[IDX_W-1:0];
	end

endmodule

// ===== sv/ima_adpcm_encoder.sv =====
// ima_adpcm_encoder: top level, input register, channel state, output register
// depends on ima_enc_pkg, ima_enc_in_if, ima_enc_out_if, ima_enc_quant
`timescale 1ns / 1ps

// Multichannel 4-bit IMA ADPCM encoder. One signed 16-bit sample word is taken
// per cycle into an input register unless a stall holds it; from there it is
// coded against its channel's predictor and step index, the channel state is
// written back and, on every second code of a pair, a packed byte (earlier code
// in the high nibble) is loaded into the output register and offered on the
// code channel. Sustained rate is one sample per cycle while the code channel
// does not stall, also for repeated samples of the same channel, set by the
// read-modify-write of the per-channel state around the coder.
// block_start restarts the pairing and drops a held code; samples for a channel
// at or above CHANNELS are dropped without a byte. A stall on the code channel
// holds the input register only when a byte is waiting and the next sample
// would complete another.
module ima_adpcm_encoder
	import ima_enc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	ima_enc_in_if.sink    samples,
	ima_enc_out_if.source codes
);

	// input register
	logic    valid_s1;
	chan_t   chan_s1;
	sample_t sample_s1;
	logic    start_s1;

	// channel state
	sample_t pred_q  [CHANNELS];
	idx_t    idx_q   [CHANNELS];
	nibble_t held_q  [CHANNELS];
	logic    phase_q [CHANNELS];

	// output register
	logic  out_valid_q;
	chan_t out_chan_q;
	byte_t out_byte_q;

	chan_state_t st;
	quant_res_t  res;
	logic        chan_ok, emit, advance;

	// coder on the registered sample
	assign st = {pred_q[chan_s1], idx_q[chan_s1]};

	ima_enc_quant u_quant (
		.smp (sample_s1),
		.st  (st),
		.res (res)
	);

	// handshake control
	assign chan_ok = int'(chan_s1) < CHANNELS;
	assign emit    = chan_ok && phase_q[chan_s1] && !start_s1;
	assign advance = valid_s1 && (!emit || !out_valid_q || codes.ready);
	assign samples.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.valid && samples.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			chan_s1   <= samples.chan;
			sample_s1 <= samples.sample;
			start_s1  <= samples.block_start;
		end
	end

	// channel state write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				pred_q[c]  <= '0;
				idx_q[c]   <= '0;
				held_q[c]  <= '0;
				phase_q[c] <= 1'b0;
			end
		end else if (advance && chan_ok) begin
			pred_q[chan_s1]  <= res.pred;
			idx_q[chan_s1]   <= res.idx;
			phase_q[chan_s1] <= !emit;
			if (!emit) held_q[chan_s1] <= res.code;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (codes.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_chan_q <= chan_s1;
			out_byte_q <= {held_q[chan_s1], res.code};
		end
	end

	assign codes.valid     = out_valid_q;
	assign codes.out_chan  = out_chan_q;
	assign codes.code_byte = out_byte_q;

	// a waiting byte is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !codes.ready |=> out_valid_q && $stable(out_byte_q))
		else $error("waiting code byte lost");

	// a byte always leaves the channel expecting a high nibble
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit |=> !phase_q[$past(chan_s1)])
		else $error("pair phase not restarted after byte");

	// per-channel bounds of index and predictor
	for (genvar g = 0; g < CHANNELS; g++) begin : g_chk
		assert property (@(posedge clk) disable iff (!arst_n)
			idx_q[g] <= STEP_MAX_INDEX && pred_q[g] != {1'b1, {(SAMPLE_W-1){1'b0}}})
			else $error("channel state out of range");
	end

endmodule

// ===== tb/sv/ima_enc_code_check.sv =====
// ima_enc_code_check: predicts the packed code bytes of the ima adpcm encoder and
// compares them with the code channel; depends on ima_enc_pkg and both interfaces
`timescale 1ns / 1ps

module ima_enc_code_check
	import ima_enc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	ima_enc_in_if  samples,
	ima_enc_out_if codes,
	output int     fail_count,
	output int     words_waiting,
	output int     samples_coded,
	output int     bytes_checked,
	output int     held_dropped,
	output int     pred_clamped,
	output int     idx_topped
);

	typedef struct packed {
		chan_t ch;
		byte_t code;
	} code_word_t;

	// bytes still owed by the block, oldest first
	code_word_t expected_bytes [$];

	// per-channel coder state
	int      pred_of [CHANNELS];
	int      idx_of  [CHANNELS];
	nibble_t held_of [CHANNELS];
	logic    odd_of  [CHANNELS];

	// one line per mismatch, printing capped so a broken block stays readable
	task automatic report(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= 100)
			$display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, want);
	endtask

	// code one accepted sample word and owe a byte when a pair completes
	task automatic code_sample(input chan_t c, input sample_t s, input logic bs);
		int      step;
		int      diff;
		int      recon;
		int      nxt_pred;
		int      nxt_idx;
		nibble_t code;
		step = int'(STEP_TABLE[idx_of[c]]);
		diff = int'(s) - pred_of[c];
		code = '0;
		// sign, then magnitude bits against step, step/2, step/4
		if (diff < 0) begin
			code[3] = 1'b1;
			diff = -diff;
		end
		if (diff >= step) begin
			code[2] = 1'b1;
			diff -= step;
		end
		if (diff >= step / 2) begin
			code[1] = 1'b1;
			diff -= step / 2;
		end
		if (diff >= step / 4)
			code[0] = 1'b1;
		// pairing, block start drops a held code
		if (bs && odd_of[c])
			held_dropped++;
		if (bs)
			odd_of[c] = 1'b0;
		if (odd_of[c]) begin
			expected_bytes.push_back(code_word_t'{ch: c, code: {held_of[c], code}});
			odd_of[c] = 1'b0;
		end else begin
			held_of[c] = code;
			odd_of[c] = 1'b1;
		end
		// rebuild predictor and saturate
		recon = step / 8;
		if (code[2])
			recon += step;
		if (code[1])
			recon += step / 2;
		if (code[0])
			recon += step / 4;
		nxt_pred = code[3] ? pred_of[c] - recon : pred_of[c] + recon;
		if (nxt_pred > 32767) begin
			nxt_pred = 32767;
			pred_clamped++;
		end else if (nxt_pred < -32767) begin
			nxt_pred = -32767;
			pred_clamped++;
		end
		pred_of[c] = nxt_pred;
		// step index: -1 for small codes, +2..+8 for large ones
		nxt_idx = code[2] ? idx_of[c] + 2 * int'(code[1:0]) + 2 : idx_of[c] - 1;
		if (nxt_idx < 0)
			nxt_idx = 0;
		else if (nxt_idx >= 88) begin
			nxt_idx = 88;
			idx_topped++;
		end
		idx_of[c] = nxt_idx;
		samples_coded++;
	endtask

	// watch both channels at every edge
	always @(posedge clk or negedge arst_n) begin : watch
		code_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pred_of[i] = 0;
				idx_of[i]  = 0;
				held_of[i] = '0;
				odd_of[i]  = 1'b0;
			end
			expected_bytes.delete();
			fail_count    = 0;
			samples_coded = 0;
			bytes_checked = 0;
			held_dropped  = 0;
			pred_clamped  = 0;
			idx_topped    = 0;
			words_waiting <= 0;
		end else begin
			// code byte word leaving the block
			if (codes.valid && codes.ready) begin
				if (expected_bytes.size() == 0)
					report("byte with none expected", int'(codes.code_byte), 0);
				else begin
					want = expected_bytes.pop_front();
					if (codes.out_chan !== want.ch)
						report("out_chan", int'(codes.out_chan), int'(want.ch));
					if (codes.code_byte !== want.code)
						report("code_byte", int'(codes.code_byte), int'(want.code));
					bytes_checked++;
				end
			end
			// sample word entering the block
			if (samples.valid && samples.ready && int'(samples.chan) < CHANNELS)
				code_sample(samples.chan, samples.sample, samples.block_start);
			words_waiting <= expected_bytes.size();
		end
	end

endmodule

// ===== tb/sv/ima_adpcm_encoder_test.sv =====
// ima_adpcm_encoder_test: drives sample words into the encoder, paces the code
// channel and gives the verdict; depends on ima_enc_pkg, the interfaces, the
// encoder and ima_enc_code_check
`timescale 1ns / 1ps

module ima_adpcm_encoder_test;
	import ima_enc_pkg::*;

	localparam int HOLD_CYCLES = 400;
	localparam sample_t S_MAX = 16'sh7fff;
	localparam sample_t S_MIN = 16'sh8000;

	logic clk;
	logic arst_n;

	ima_enc_in_if  samples_if ();
	ima_enc_out_if codes_if ();

	int fail_count;
	int words_waiting;
	int samples_coded;
	int bytes_checked;
	int held_dropped;
	int pred_clamped;
	int idx_topped;

	int   send_idle_pct;
	int   recv_idle_pct;
	logic hold_req;
	int   hold_left;
	int   walk [CHANNELS];

	ima_adpcm_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samples(samples_if),
		.codes  (codes_if)
	);

	ima_enc_code_check u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.samples      (samples_if),
		.codes        (codes_if),
		.fail_count   (fail_count),
		.words_waiting(words_waiting),
		.samples_coded(samples_coded),
		.bytes_checked(bytes_checked),
		.held_dropped (held_dropped),
		.pred_clamped (pred_clamped),
		.idx_topped   (idx_topped)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("ima_adpcm_encoder_test: errors");
		$finish;
	end

	// code channel pacing, with one long hold-off on request
	initial begin
		codes_if.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				codes_if.ready <= 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				codes_if.ready <= 1'b0;
			end else
				codes_if.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// offer one sample word, with random gaps before it, until accepted
	task automatic put_sample(input chan_t c, input sample_t s, input logic bs);
		while ($urandom_range(99) < send_idle_pct) begin
			samples_if.valid <= 1'b0;
			@(posedge clk);
		end
		samples_if.valid       <= 1'b1;
		samples_if.chan        <= c;
		samples_if.sample      <= s;
		samples_if.block_start <= bs;
		@(posedge clk);
		while (!samples_if.ready)
			@(posedge clk);
	endtask

	// audio-like walks per channel, with jumps, full-range noise and extremes
	task automatic random_run(input int count);
		chan_t c;
		int    mode;
		int    v;
		for (int n = 0; n < count; n++) begin
			c = chan_t'($urandom_range(CHANNELS - 1));
			mode = $urandom_range(99);
			if (mode < 60)
				v = walk[c] + $urandom_range(4000) - 2000;
			else if (mode < 85)
				v = walk[c] + $urandom_range(32000) - 16000;
			else if (mode < 93)
				v = int'(sample_t'($urandom_range(16'hffff)));
			else
				v = $urandom_range(1) ? 32767 : -32768;
			if (v > 32767)
				v = 32767;
			else if (v < -32768)
				v = -32768;
			walk[c] = v;
			put_sample(c, sample_t'(v), $urandom_range(99) < 6);
		end
	endtask

	// stimulus
	initial begin
		arst_n = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.chan = '0;
		samples_if.sample = '0;
		samples_if.block_start = 1'b0;
		hold_req = 1'b0;
		send_idle_pct = 11;
		recv_idle_pct = 74;
		walk[0] = 0;
		walk[1] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// index floor with silence, then a plain pair
		put_sample(1'b0, 16'sd0, 1'b0);
		put_sample(1'b0, 16'sd0, 1'b0);
		// block start on a fresh pair, then one that drops a held code
		put_sample(1'b1, -16'sd1, 1'b1);
		put_sample(1'b1, S_MAX, 1'b1);
		put_sample(1'b1, 16'sd1, 1'b0);
		// full swings drive the index to its ceiling and the predictor to both rails
		for (int i = 0; i < 14; i++)
			put_sample(1'b0, i[0] ? S_MIN : S_MAX, 1'b0);
		// on the other channel, climb toward the rail, then swing back toward zero
		for (int i = 0; i < 4; i++)
			put_sample(1'b1, S_MAX, 1'b0);
		put_sample(1'b1, S_MIN, 1'b0);
		put_sample(1'b1, 16'sd0, 1'b1);

		random_run(400);
		send_idle_pct = 74;
		recv_idle_pct = 11;
		random_run(410);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		random_run(415);
		samples_if.valid <= 1'b0;

		// drain
		while (words_waiting != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("coded %0d samples on %0d channels, checked %0d code bytes",
			samples_coded, CHANNELS, bytes_checked);
		$display("held codes dropped by block start: %0d, predictor clamps: %0d, index at top: %0d",
			held_dropped, pred_clamped, idx_topped);
		if (fail_count == 0)
			$display("ima_adpcm_encoder_test: clean");
		else
			$display("ima_adpcm_encoder_test: errors");
		$finish;
	end

endmodule
